// File: design/sorted_unique_set_store_macros.svh
// assertion macros shared by the set store rtl
// expects clk and rst in the scope of each use
`ifndef SORTED_UNIQUE_SET_STORE_MACROS_SVH
`define SORTED_UNIQUE_SET_STORE_MACROS_SVH

// check that holds in the same cycle as its trigger
`define SUSS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// check that holds in the cycle after its trigger
`define SUSS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/suss_pkg.sv
// shared types and codes for the sorted unique set store
// no dependencies
package suss_pkg;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LIST   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // command word
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } req_t;

  // result word
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [3:0]         count;
    logic               is_empty;
    logic               is_full;
    logic               last;
  } rsp_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } cell_ctl_t;

endpackage

// File: design/suss_cell.sv
// one slot of the sorted chain: holds a value, compares it with the command
// value and shifts with its neighbors; depends on suss_pkg
module suss_cell (
  input  logic                 clk,
  input  suss_pkg::cell_ctl_t  ctl,
  input  logic                 occ,
  input  logic signed [31:0]   v,
  input  logic signed [31:0]   left_entry,
  input  logic                 left_above,
  input  logic signed [31:0]   right_entry,
  output logic signed [31:0]   entry,
  output logic                 above,
  output logic                 match
);
  import suss_pkg::*;

  // slot lies above the insertion point, or holds a larger value
  assign above = !occ || (entry > v);
  assign match = occ && (entry == v);

  // insert pulls from the left, delete and rotate pull from the right
  always_ff @(posedge clk) begin
    if (ctl.ins && above) begin
      entry <= left_above ? left_entry : v;
    end else if (ctl.del && occ && (above || match)) begin
      entry <= right_entry;
    end else if (ctl.rot && occ) begin
      entry <= right_entry;
    end
  end

endmodule

// File: design/sorted_unique_set_store.sv
// insert, delete and other actions: result in the cycle after start, one word per cycle while not busy.
// list: busy while in S_LIST; results follow the state register and the result register, one word per cycle,
// read out of the head cell while the occupied cells rotate by one each cycle.
// an empty list gives a single word in the cycle after start.
// rst clears the fill count; stored values are not cleared. receiver cannot stall.
`include "sorted_unique_set_store_macros.svh"

module sorted_unique_set_store #(
  parameter int CAPACITY = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  suss_pkg::req_t req,
  output logic           strobe,
  output suss_pkg::rsp_t rsp
);
  import suss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(CAPACITY);

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t  state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] rem, rem_next;
  logic          strobe_next;
  rsp_t          rsp_next;
  logic [CW+3:0] fill_ext;
  cell_ctl_t     ctl;
  logic          accept, full, dup, found;

  logic signed [31:0] entry_a [CAPACITY];
  logic [CAPACITY-1:0] above_v, match_v, occ_v;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic signed [31:0] left_e, right_e;
    logic               left_a;

    assign occ_v[i] = fill > IDX;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_a = 1'b0;
    end else begin : g_body
      assign left_e = entry_a[i-1];
      assign left_a = above_v[i-1];
    end

    // the last occupied cell wraps to the head for rotation
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = entry_a[0];
    end else begin : g_mid
      assign right_e = occ_v[i+1] ? entry_a[i+1] : entry_a[0];
    end

    suss_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ_v[i]),
      .v           (req.value),
      .left_entry  (left_e),
      .left_above  (left_a),
      .right_entry (right_e),
      .entry       (entry_a[i]),
      .above       (above_v[i]),
      .match       (match_v[i])
    );
  end

  assign busy   = (state == S_LIST);
  assign accept = start && !busy;
  assign full   = (fill == FILL_MAX);
  assign dup    = |match_v;
  assign found  = |match_v;

  // action decode and next result word
  always_comb begin
    state_next  = state;
    fill_next   = fill;
    rem_next    = rem;
    strobe_next = 1'b0;
    ctl         = '0;
    rsp_next    = '0;
    rsp_next.status = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next   = 1'b1;
          rsp_next.last = 1'b1;
          case (req.action)
            ACT_INSERT: begin
              if (full) begin
                rsp_next.status = ST_FULL;
              end else if (dup) begin
                rsp_next.status = ST_DUP;
              end else begin
                ctl.ins   = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            ACT_DELETE: begin
              if (fill == '0) begin
                rsp_next.status = ST_EMPTY;
              end else if (!found) begin
                rsp_next.status = ST_NOTFOUND;
              end else begin
                ctl.del   = 1'b1;
                fill_next = fill - 1'b1;
              end
            end
            ACT_LIST: begin
              if (fill == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                strobe_next = 1'b0;
                state_next  = S_LIST;
                rem_next    = fill;
              end
            end
            default: begin
              rsp_next.status = ST_OK;
            end
          endcase
        end
      end
      S_LIST: begin
        strobe_next      = 1'b1;
        ctl.rot          = 1'b1;
        rsp_next.element = entry_a[0];
        rsp_next.last    = (rem == CW'(1));
        rem_next         = rem - 1'b1;
        if (rem == CW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    fill_ext          = {4'b0, fill_next};
    rsp_next.count    = fill_ext[3:0];
    rsp_next.is_empty = (fill_next == '0);
    rsp_next.is_full  = (fill_next == FILL_MAX);
  end

  // state, fill count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      rem    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      rem    <= rem_next;
      strobe <= strobe_next;
    end
    rsp <= rsp_next;
  end

  // checks
  `SUSS_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_MAX, "fill count past capacity")
  `SUSS_ASSERT_NEXT(a_single_word, accept && (req.action != ACT_LIST), strobe, "missing result word")
  `SUSS_ASSERT_NEXT(a_list_emits, busy, strobe, "list cycle without result word")
  `SUSS_ASSERT_NOW(a_more_follows, strobe && !rsp.last, busy, "list ended before last word")
  `SUSS_ASSERT_NEXT(a_full_reject, accept && (req.action == ACT_INSERT) && full, rsp.status == ST_FULL, "insert into full set not rejected")

endmodule

// File: dv/tb_sorted_unique_set_store.sv
// self-checking testbench for the sorted unique set store
// depends on suss_pkg and sorted_unique_set_store; predicts every result word and compares
`timescale 1ns / 1ps

module tb_sorted_unique_set_store;
  import suss_pkg::*;

  localparam int SET_CAP = 8;
  // action code that the block must treat as a no-op
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic strobe;
  rsp_t rsp;

  // command words waiting to be driven, result words still due
  req_t cmd_words[$];
  rsp_t result_words_due[$];
  // predicted contents of the set, ascending
  int held_vals[$];
  int mismatches = 0;
  int idle_left = 0;
  logic steady = 1'b0;
  int value_pool[12];

  sorted_unique_set_store #(.CAPACITY(SET_CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .strobe(strobe),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one accepted command word to the predicted set and queue its results
  task automatic predict_set_op(input req_t w);
    rsp_t r;
    int v;
    int idx;
    v = w.value;
    idx = -1;
    r = '0;
    for (int i = 0; i < held_vals.size(); i++) begin
      if (held_vals[i] == v) idx = i;
    end
    case (w.action)
      ACT_INSERT: begin
        if (held_vals.size() >= SET_CAP) begin
          r.status = ST_FULL;
        end else if (idx >= 0) begin
          r.status = ST_DUP;
        end else begin
          idx = 0;
          while (idx < held_vals.size() && held_vals[idx] < v) idx++;
          held_vals.insert(idx, v);
          r.status = ST_OK;
        end
      end
      ACT_DELETE: begin
        if (held_vals.size() == 0) r.status = ST_EMPTY;
        else if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          held_vals.delete(idx);
          r.status = ST_OK;
        end
      end
      ACT_LIST: begin
        if (held_vals.size() == 0) r.status = ST_EMPTY;
        else r.status = ST_OK;
      end
      default: r.status = ST_OK;
    endcase
    r.count = 4'(held_vals.size());
    r.is_empty = (held_vals.size() == 0);
    r.is_full = (held_vals.size() >= SET_CAP);
    if (w.action == ACT_LIST && held_vals.size() != 0) begin
      // one word per stored value, last marker on the top one
      for (int i = 0; i < held_vals.size(); i++) begin
        r.element = held_vals[i];
        r.last = (i == held_vals.size() - 1);
        result_words_due.push_back(r);
      end
    end else begin
      r.element = '0;
      r.last = 1'b1;
      result_words_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
    end
  endtask

  task automatic push_cmd(input logic [1:0] action, input int value);
    req_t w;
    w.action = action;
    w.value = value;
    cmd_words.push_back(w);
  endtask

  // pick a value: mostly from a small pool so hits and duplicates are common
  function automatic int pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  // driver: issues queued command words with random idle gaps
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      idle_left <= 0;
    end else if (start && busy) begin
      // hold the word until the block takes it
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (cmd_words.size() != 0) begin
      start <= 1'b1;
      req <= cmd_words.pop_front();
      if ($urandom_range(0, 99) < 4) steady <= !steady;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) idle_left <= 0;
      else if (pick < 90) idle_left <= $urandom_range(1, 3);
      else idle_left <= $urandom_range(4, 25);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predicts on each accepted command, checks each result word
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (start && !busy) predict_set_op(req);
      if (strobe) begin
        if (result_words_due.size() == 0) begin
          mismatches++;
          $error("result word with none expected: status %0d element %0d",
                 rsp.status, rsp.element);
        end else begin
          want = result_words_due.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("element", want.element, rsp.element);
          check_field("count", 32'(want.count), 32'(rsp.count));
          check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
          check_field("last", 32'(want.last), 32'(rsp.last));
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    logic fill_bias;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 12; i++) value_pool[i] = $urandom_range(0, 40) - 20;

    // directed: empty cases, extremes, full, duplicate, not found, deletes at every position
    push_cmd(ACT_LIST, 0);
    push_cmd(ACT_DELETE, 5);
    push_cmd(ACT_INSERT, 0);
    push_cmd(ACT_INSERT, 32'sh7fff_ffff);
    push_cmd(ACT_INSERT, 32'sh8000_0000);
    push_cmd(ACT_INSERT, 0);
    push_cmd(ACT_INSERT, -1);
    push_cmd(ACT_INSERT, 1);
    push_cmd(ACT_INSERT, 100);
    push_cmd(ACT_INSERT, -100);
    push_cmd(ACT_INSERT, 7);
    push_cmd(ACT_INSERT, 42);
    push_cmd(ACT_INSERT, 32'sh7fff_ffff);
    push_cmd(ACT_LIST, -1);
    push_cmd(ACT_UNDEF, -1);
    push_cmd(ACT_DELETE, 3);
    push_cmd(ACT_DELETE, 32'sh8000_0000);
    push_cmd(ACT_DELETE, 32'sh7fff_ffff);
    push_cmd(ACT_DELETE, 0);
    push_cmd(ACT_LIST, 0);
    push_cmd(ACT_DELETE, -100);
    push_cmd(ACT_DELETE, -1);
    push_cmd(ACT_DELETE, 1);
    push_cmd(ACT_DELETE, 100);
    push_cmd(ACT_DELETE, 7);

    // random: alternate fill-leaning and drain-leaning stretches
    fill_bias = 1'b1;
    for (int n = 0; n < 405; n++) begin
      if (n % 30 == 0) fill_bias = !fill_bias;
      if ($urandom_range(0, 99) < 3) value_pool[$urandom_range(4, 11)] = $urandom;
      pick = $urandom_range(0, 99);
      if (fill_bias) begin
        if (pick < 60) push_cmd(ACT_INSERT, pick_value());
        else if (pick < 80) push_cmd(ACT_DELETE, pick_value());
        else if (pick < 95) push_cmd(ACT_LIST, $urandom);
        else push_cmd(ACT_UNDEF, $urandom);
      end else begin
        if (pick < 25) push_cmd(ACT_INSERT, pick_value());
        else if (pick < 70) push_cmd(ACT_DELETE, pick_value());
        else if (pick < 92) push_cmd(ACT_LIST, $urandom);
        else push_cmd(ACT_UNDEF, $urandom);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_words.size() != 0 || start) @(posedge clk);
    while (result_words_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/suss_pkg.sv
design/suss_cell.sv
design/sorted_unique_set_store.sv
dv/tb_sorted_unique_set_store.sv
